[hdl/rv32m_pkg.sv]
// shared types and constants for the rv32m multiply/divide unit
package rv32m_pkg;

  localparam int XLEN = 32;
  localparam int IDXW = 5;
  localparam int DIV_STAGES = XLEN;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [XLEN-1:0] first_operand;
    logic [XLEN-1:0] second_operand;
    logic [IDXW-1:0] dest_index;
  } req_t;

  typedef struct packed {
    logic [IDXW-1:0] write_index;
    logic [XLEN-1:0] write_value;
  } rsp_t;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic            vld;
    logic [IDXW-1:0] idx;
    logic            is_mul;
    logic [XLEN-1:0] mul_res;
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic            special;
    logic [XLEN-1:0] special_val;
    logic [XLEN-1:0] dvd;
    logic [XLEN-1:0] dvs;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
  } cell_t;

endpackage

[hdl/rv32m_div_cell.sv]
// one restoring division step, registered, passing its state to the next cell
module rv32m_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  rv32m_pkg::cell_t  cin,
  output rv32m_pkg::cell_t  cout
);

  rv32m_pkg::cell_t cell_nxt;
  rv32m_pkg::cell_t cell_r;
  logic [rv32m_pkg::XLEN:0] trial;
  logic [rv32m_pkg::XLEN:0] diff;

  always_comb begin
    cell_nxt = cin;
    trial = {cin.rem, cin.dvd[rv32m_pkg::XLEN-1]};
    diff = trial - {1'b0, cin.dvs};
    cell_nxt.dvd = {cin.dvd[rv32m_pkg::XLEN-2:0], 1'b0};
    if (!diff[rv32m_pkg::XLEN]) begin
      cell_nxt.rem = diff[rv32m_pkg::XLEN-1:0];
      cell_nxt.quo = {cin.quo[rv32m_pkg::XLEN-2:0], 1'b1};
    end else begin
      cell_nxt.rem = trial[rv32m_pkg::XLEN-1:0];
      cell_nxt.quo = {cin.quo[rv32m_pkg::XLEN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (adv) begin
      cell_r.idx         <= cell_nxt.idx;
      cell_r.is_mul      <= cell_nxt.is_mul;
      cell_r.mul_res     <= cell_nxt.mul_res;
      cell_r.want_rem    <= cell_nxt.want_rem;
      cell_r.neg_q       <= cell_nxt.neg_q;
      cell_r.neg_r       <= cell_nxt.neg_r;
      cell_r.special     <= cell_nxt.special;
      cell_r.special_val <= cell_nxt.special_val;
      cell_r.dvd         <= cell_nxt.dvd;
      cell_r.dvs         <= cell_nxt.dvs;
      cell_r.rem         <= cell_nxt.rem;
      cell_r.quo         <= cell_nxt.quo;
    end
  end

  assign cout = cell_r;

endmodule

[hdl/rv32m_mul_front.sv]
// input register, 33x33 signed multiply and divider operand setup
module rv32m_mul_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  rv32m_pkg::req_t   req,
  output rv32m_pkg::cell_t  cout
);

  localparam int W = rv32m_pkg::XLEN;

  rv32m_pkg::req_t req_r;
  logic            vld_r;
  logic signed [W:0]     ma;
  logic signed [W:0]     mb;
  logic signed [2*W+1:0] prod;
  logic                  an;
  logic                  bn;
  logic [W-1:0]          absa;
  logic [W-1:0]          absb;
  logic                  is_signed;
  logic                  by_zero;
  logic                  ovf;
  rv32m_pkg::op_t        op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
    if (adv) begin
      req_r <= req;
    end
  end

  always_comb begin
    op = rv32m_pkg::op_t'(req_r.req_type);
    an = req_r.first_operand[W-1];
    bn = req_r.second_operand[W-1];
    ma = {(op == rv32m_pkg::OP_MULH || op == rv32m_pkg::OP_MULHSU) & an,
          req_r.first_operand};
    mb = {(op == rv32m_pkg::OP_MULH) & bn, req_r.second_operand};
    prod = ma * mb;
    is_signed = (op == rv32m_pkg::OP_DIV) || (op == rv32m_pkg::OP_REM);
    absa = (is_signed && an) ? (~req_r.first_operand + 1'b1) : req_r.first_operand;
    absb = (is_signed && bn) ? (~req_r.second_operand + 1'b1) : req_r.second_operand;
    by_zero = (req_r.second_operand == '0);
    ovf = is_signed && (req_r.first_operand == {1'b1, {(W-1){1'b0}}})
          && (req_r.second_operand == '1);

    cout.vld = vld_r;
    cout.idx = req_r.dest_index;
    cout.is_mul = !req_r.req_type[2];
    cout.mul_res = (op == rv32m_pkg::OP_MUL) ? prod[W-1:0] : prod[2*W-1:W];
    cout.want_rem = req_r.req_type[1];
    cout.neg_q = is_signed && (an != bn);
    cout.neg_r = is_signed && an;
    cout.special = by_zero || ovf;
    if (by_zero) begin
      cout.special_val = req_r.req_type[1] ? req_r.first_operand : '1;
    end else begin
      cout.special_val = req_r.req_type[1] ? '0 : req_r.first_operand;
    end
    cout.dvd = absa;
    cout.dvs = absb;
    cout.rem = '0;
    cout.quo = '0;
  end

endmodule

[hdl/rv32m_multiply_divide_unit.sv]
// top level of the rv32m multiply/divide unit
//
// usage: one transaction on the in_ channel carries an op code, two raw
// operands and a destination index; exactly one transaction comes back on
// the out_ channel with that index and the 32-bit result, in request order.
// transactions are taken with in_valid high and in_stall low, delivered with
// out_valid high and out_stall low.
// structure: a front stage registers the request and forms the 33x33
// product plus magnitude operands, then a chain of 32 identical division
// cells each resolves one quotient bit and hands its state on. multiplies
// ride the same chain so results stay in order. a final stage fixes signs
// and special cases into the output register.
// path: the front register loads at the accepting edge, then the 32 cells
// load in turn, then the output register.
// throughput: one per cycle when not frozen; the whole pipe advances together.
// when out_stall is high and the output register holds a result, the whole
// pipe freezes and in_stall rises; an empty output register never blocks
// the input.
// reset: synchronous active-low rst_n clears every valid bit; no results
// are in flight afterwards.
module rv32m_multiply_divide_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rv32m_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rv32m_pkg::rsp_t  out_data
);

  localparam int N = rv32m_pkg::DIV_STAGES;

  rv32m_pkg::cell_t chain [0:N];
  rv32m_pkg::rsp_t  out_r;
  rv32m_pkg::rsp_t  out_nxt;
  logic             out_vld_r;
  logic             adv;
  logic [rv32m_pkg::XLEN-1:0] q_fix;
  logic [rv32m_pkg::XLEN-1:0] r_fix;

  // pipe moves whenever the output register is free or being drained
  assign adv = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  rv32m_mul_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_vld(in_valid),
    .req   (in_data),
    .cout  (chain[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    rv32m_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  // sign fixup and result select
  always_comb begin
    q_fix = chain[N].neg_q ? (~chain[N].quo + 1'b1) : chain[N].quo;
    r_fix = chain[N].neg_r ? (~chain[N].rem + 1'b1) : chain[N].rem;
    out_nxt.write_index = chain[N].idx;
    if (chain[N].is_mul) begin
      out_nxt.write_value = chain[N].mul_res;
    end else if (chain[N].special) begin
      out_nxt.write_value = chain[N].special_val;
    end else begin
      out_nxt.write_value = chain[N].want_rem ? r_fix : q_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= chain[N].vld;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[hdl/rv32m_checker.sv]
// port-level checks for the rv32m multiply/divide unit
module rv32m_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input rv32m_pkg::rsp_t  out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rv32m_multiply_divide_unit rv32m_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
